@@ src/rvn_pkg.sv @@
// ----------------------------------------------------------------------------
// rvn_pkg
// Shared types and constants for the row pass nearest-feature block.
// ----------------------------------------------------------------------------
`default_nettype none

package rvn_pkg;

	localparam int ROW_W = 10;
	localparam int COL_W = 10;
	localparam int SITE_W = ROW_W + COL_W;
	localparam int BND_W = 32;
	localparam int CFG_W = 11;

	localparam int DEF_MAX_COLS = 1024;
	localparam int DEF_FRAC_BITS = 8;

	localparam logic [CFG_W-1:0] COLS_RESET = 11'd1024;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// Register index, taken from paddr[2].
	localparam logic REG_COLS_IN_USE = 1'b0;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} site_t;

	typedef struct packed {
		site_t a;
		site_t b;
		logic [ROW_W-1:0] k;
	} bnd_req_t;

endpackage

`default_nettype wire

@@ src/row_voronoi_nearest_feature.sv @@
// Load: a skipped column returns straight to idle; otherwise each boundary is
// computed with the bit-serial divider. Every comparison of the top two sites
// (one per pop and the last one that keeps the top) costs two boundaries and a
// site read, or one boundary when a single site is held; then the site is pushed.
// Read: a stack read and a compare for each site stepped over, none for an empty
// row; the output can stall. One item is in work at a time. Reset empties the
// stack, clears the pointers and sets 1024 columns.
// ----------------------------------------------------------------------------
// row_voronoi_nearest_feature
// Row pass of a Euclidean distance transform: site stack in memory, bisector
// pops on load, ordered walk over the Voronoi intervals on read.
// ----------------------------------------------------------------------------
`default_nettype none

module row_voronoi_nearest_feature #(
	parameter int MAX_COLS = rvn_pkg::DEF_MAX_COLS,
	parameter int FRAC_BITS = rvn_pkg::DEF_FRAC_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// row_index [9:0], column [19:10], feature_present [20], feature_row [30:21]
	input  wire logic [31:0] s_axis_tdata,
	// action [0]
	input  wire logic [0:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// nearest_row [9:0], nearest_col [19:10]
	output logic [23:0]      m_axis_tdata,
	// row_empty [0]
	output logic [0:0]       m_axis_tuser,
	output logic             m_axis_tlast
);

	localparam int AW = $clog2(MAX_COLS);
	localparam int TW = AW + 1;
	localparam int CLG = $clog2(MAX_COLS + 1);
	localparam int EW = (CLG > rvn_pkg::CFG_W) ? CLG : rvn_pkg::CFG_W;
	localparam int XW = rvn_pkg::BND_W + 1;
	localparam logic REG_COLS_IN_USE_L = rvn_pkg::REG_COLS_IN_USE;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_LRD  = 10'b0000000010,
		S_Y1S  = 10'b0000000100,
		S_Y1W  = 10'b0000001000,
		S_Y2S  = 10'b0000010000,
		S_Y2W  = 10'b0000100000,
		S_PUSH = 10'b0001000000,
		S_RRD  = 10'b0010000000,
		S_RCMP = 10'b0100000000,
		S_OUT  = 10'b1000000000
	} st_t;

	st_t                          state_q;
	logic [rvn_pkg::CFG_W-1:0]    cols_q;
	logic [TW-1:0]                top_q;
	logic [AW-1:0]                emit_q;
	rvn_pkg::site_t               top_site_q;
	rvn_pkg::site_t               a_q;
	rvn_pkg::site_t               now_q;
	logic [rvn_pkg::ROW_W-1:0]    k_q;
	logic [rvn_pkg::COL_W-1:0]    rcol_q;
	logic signed [rvn_pkg::BND_W-1:0] y1_q;
	logic signed [rvn_pkg::BND_W-1:0] y2_q;
	rvn_pkg::site_t               res_site_q;
	logic                         res_empty_q;
	logic                         res_last_q;

	logic [EW-1:0]                eff_cols;
	logic [rvn_pkg::ROW_W-1:0]    in_k;
	logic [rvn_pkg::COL_W-1:0]    in_col;
	logic                         in_pres;
	logic [rvn_pkg::ROW_W-1:0]    in_frow;
	logic                         in_act;
	logic                         in_xfer;
	logic [TW-1:0]                top_n;
	logic [AW-1:0]                emit_n;
	logic                         load_ok;
	logic                         in_last;
	logic [TW-1:0]                top_m1;
	logic [TW-1:0]                top_m2;
	logic [TW-1:0]                top_p1;

	logic                         stk_we;
	logic [AW-1:0]                stk_raddr;
	logic [rvn_pkg::SITE_W-1:0]   stk_rdata;
	rvn_pkg::site_t               stk_site;
	logic                         bnd_we;
	logic [rvn_pkg::BND_W-1:0]    bnd_rdata;

	logic                         b_start;
	rvn_pkg::bnd_req_t            b_req;
	logic                         b_done;
	logic signed [rvn_pkg::BND_W-1:0] b_value;

	logic [XW-1:0]                colfx;
	logic                         step_on;
	logic                         out_free;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_COLS_IN_USE_L) ? 32'(cols_q) : 32'd0;

	always_comb begin
		if (cols_q == '0) begin
			eff_cols = EW'(1);
		end else if (EW'(cols_q) > EW'(MAX_COLS)) begin
			eff_cols = EW'(MAX_COLS);
		end else begin
			eff_cols = EW'(cols_q);
		end
	end

	assign in_k = s_axis_tdata[9:0];
	assign in_col = s_axis_tdata[19:10];
	assign in_pres = s_axis_tdata[20];
	assign in_frow = s_axis_tdata[30:21];
	assign in_act = s_axis_tuser[0];

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	assign top_n = (in_col == '0) ? '0 : top_q;
	assign emit_n = (in_col == '0) ? '0 : emit_q;
	assign in_last = (EW'(in_col) == eff_cols - EW'(1));
	assign load_ok = (EW'(in_col) < eff_cols) && in_pres
		&& !((top_n != '0) && (top_site_q.col >= in_col))
		&& (top_n < TW'(MAX_COLS));

	assign top_m1 = top_q - TW'(1);
	assign top_m2 = top_q - TW'(2);
	assign top_p1 = top_q + TW'(1);

	assign stk_site = rvn_pkg::site_t'(stk_rdata);
	assign stk_raddr = (state_q == S_RRD) ? emit_q : top_m2[AW-1:0];
	assign stk_we = (state_q == S_PUSH);
	assign bnd_we = (state_q == S_PUSH) && (top_q != '0);

	rvn_ram #(
		.WIDTH(rvn_pkg::SITE_W),
		.DEPTH(MAX_COLS)
	) u_site_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(top_q[AW-1:0]),
		.wdata(now_q),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	rvn_ram #(
		.WIDTH(rvn_pkg::BND_W),
		.DEPTH(MAX_COLS)
	) u_bnd_ram (
		.clk  (clk),
		.we   (bnd_we),
		.waddr(top_m1[AW-1:0]),
		.wdata(y2_q),
		.raddr(emit_q),
		.rdata(bnd_rdata)
	);

	assign b_start = (state_q == S_Y1S) || (state_q == S_Y2S);
	always_comb begin
		b_req.k = k_q;
		if (state_q == S_Y1S) begin
			b_req.a = stk_site;
			b_req.b = top_site_q;
		end else begin
			b_req.a = top_site_q;
			b_req.b = now_q;
		end
	end

	rvn_boundary #(
		.FRAC_BITS(FRAC_BITS)
	) u_boundary (
		.clk   (clk),
		.arst_n(arst_n),
		.start (b_start),
		.req   (b_req),
		.done  (b_done),
		.value (b_value)
	);

	// Column in the same fixed point as the stored boundaries.
	assign colfx = XW'(rcol_q) << FRAC_BITS;
	assign step_on = (({1'b0, emit_q} + TW'(1)) < top_q)
		&& ($signed(colfx) > $signed({bnd_rdata[rvn_pkg::BND_W-1], bnd_rdata}));
	assign out_free = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cols_q <= rvn_pkg::COLS_RESET;
			top_q <= '0;
			emit_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && (paddr[2] == REG_COLS_IN_USE_L)) begin
				cols_q <= pwdata[rvn_pkg::CFG_W-1:0];
			end
			if ((state_q == S_OUT) && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (in_act == rvn_pkg::ACT_LOAD) begin
							top_q <= top_n;
							emit_q <= emit_n;
							if (load_ok) begin
								if (top_n == '0) begin
									state_q <= S_PUSH;
								end else if (top_n == TW'(1)) begin
									state_q <= S_Y2S;
								end else begin
									state_q <= S_LRD;
								end
							end
						end else begin
							if (top_q == '0) begin
								emit_q <= emit_n;
								state_q <= S_OUT;
							end else begin
								if ({1'b0, emit_n} >= top_q) begin
									emit_q <= top_m1[AW-1:0];
								end else begin
									emit_q <= emit_n;
								end
								state_q <= S_RRD;
							end
						end
					end
				end
				S_LRD: state_q <= S_Y1S;
				S_Y1S: state_q <= S_Y1W;
				S_Y1W: begin
					if (b_done) begin
						state_q <= S_Y2S;
					end
				end
				S_Y2S: state_q <= S_Y2W;
				S_Y2W: begin
					if (b_done) begin
						if ((top_q >= TW'(2)) && (y1_q > b_value)) begin
							top_q <= top_m1;
							state_q <= (top_m1 >= TW'(2)) ? S_LRD : S_Y2S;
						end else begin
							state_q <= S_PUSH;
						end
					end
				end
				S_PUSH: begin
					top_q <= top_p1;
					if ({1'b0, emit_q} >= top_p1) begin
						emit_q <= top_q[AW-1:0];
					end
					state_q <= S_IDLE;
				end
				S_RRD: state_q <= S_RCMP;
				S_RCMP: begin
					if (step_on) begin
						emit_q <= emit_q + AW'(1);
						state_q <= S_RRD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			k_q <= in_k;
			rcol_q <= in_col;
			now_q <= '{row: in_frow, col: in_col};
			res_last_q <= in_last;
			res_empty_q <= (top_q == '0);
			res_site_q <= '0;
		end
		if (state_q == S_Y1S) begin
			a_q <= stk_site;
		end
		if ((state_q == S_Y1W) && b_done) begin
			y1_q <= b_value;
		end
		if ((state_q == S_Y2W) && b_done) begin
			y2_q <= b_value;
			if ((top_q >= TW'(2)) && (y1_q > b_value)) begin
				top_site_q <= a_q;
			end
		end
		if (state_q == S_PUSH) begin
			top_site_q <= now_q;
		end
		if ((state_q == S_RCMP) && !step_on) begin
			res_site_q <= stk_site;
		end
		if ((state_q == S_OUT) && out_free) begin
			m_axis_tdata <= {4'd0, res_site_q.col, res_site_q.row};
			m_axis_tuser <= res_empty_q;
			m_axis_tlast <= res_last_q;
		end
	end

endmodule

`default_nettype wire

@@ src/rvn_ram.sv @@
// ----------------------------------------------------------------------------
// rvn_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rvn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ src/rvn_boundary.sv @@
// ----------------------------------------------------------------------------
// rvn_boundary
// Bisector boundary of two sites in signed fixed point, with a bit-serial
// restoring divider for the truncating division.
// ----------------------------------------------------------------------------
`default_nettype none

module rvn_boundary #(
	parameter int FRAC_BITS = rvn_pkg::DEF_FRAC_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire rvn_pkg::bnd_req_t           req,
	output logic                             done,
	output logic signed [rvn_pkg::BND_W-1:0] value
);

	localparam int PW = 24;
	localparam int NW = PW - 1 + FRAC_BITS;
	localparam int VW = (NW + 2 > 33) ? NW + 2 : 33;
	localparam int DW = 12;
	localparam int CW = $clog2(NW);
	localparam logic signed [VW-1:0] SAT_MAX = VW'(64'sh7FFF_FFFF);
	localparam logic signed [VW-1:0] SAT_MIN = -SAT_MAX - VW'(1);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_MUL  = 5'b00010,
		B_PREP = 5'b00100,
		B_DIV  = 5'b01000,
		B_FIN  = 5'b10000
	} bst_t;

	bst_t                   state_q;
	logic signed [10:0]     dr_q;
	logic signed [12:0]     sm_q;
	logic signed [DW-1:0]   den_q;
	logic signed [VW-1:0]   base_q;
	logic signed [PW-1:0]   prod_q;
	logic                   neg_q;
	logic                   denz_q;
	logic [NW-1:0]          mag_q;
	logic [DW-1:0]          rem_q;
	logic [CW-1:0]          cnt_q;

	logic signed [10:0]     dc;
	logic signed [PW+FRAC_BITS-1:0] num;
	logic signed [PW+FRAC_BITS-1:0] num_abs;
	logic [DW-1:0]          rsh;
	logic                   qbit;
	logic signed [VW-1:0]   qv;
	logic signed [VW-1:0]   vsum;

	assign dc = $signed({1'b0, req.b.col}) - $signed({1'b0, req.a.col});
	assign num = {prod_q, {FRAC_BITS{1'b0}}};
	assign num_abs = prod_q[PW-1] ? -num : num;
	assign rsh = {rem_q[DW-2:0], mag_q[NW-1]};
	assign qbit = rsh >= DW'(den_q);
	assign qv = neg_q ? -$signed(VW'(mag_q)) : $signed(VW'(mag_q));
	assign vsum = base_q + (denz_q ? VW'(0) : qv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (start) begin
						state_q <= B_MUL;
					end
				end
				B_MUL:  state_q <= B_PREP;
				B_PREP: state_q <= B_DIV;
				B_DIV: begin
					if (cnt_q == '0) begin
						state_q <= B_FIN;
					end
				end
				B_FIN: begin
					done <= 1'b1;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				dr_q <= $signed({1'b0, req.b.row}) - $signed({1'b0, req.a.row});
				sm_q <= $signed({3'b0, req.a.row}) + $signed({3'b0, req.b.row})
					- $signed({2'b0, req.k, 1'b0});
				den_q <= {dc, 1'b0};
				base_q <= $signed(VW'({1'b0, req.a.col} + {1'b0, req.b.col})
					<< (FRAC_BITS - 1));
			end
			B_MUL: begin
				prod_q <= PW'(dr_q * sm_q);
			end
			B_PREP: begin
				neg_q <= prod_q[PW-1];
				denz_q <= (den_q <= 0);
				mag_q <= num_abs[NW-1:0];
				rem_q <= '0;
				cnt_q <= CW'(NW - 1);
			end
			B_DIV: begin
				rem_q <= qbit ? rsh - DW'(den_q) : rsh;
				mag_q <= {mag_q[NW-2:0], qbit};
				cnt_q <= cnt_q - CW'(1);
			end
			B_FIN: begin
				if (vsum > SAT_MAX) begin
					value <= 32'sh7FFF_FFFF;
				end else if (vsum < SAT_MIN) begin
					value <= 32'sh8000_0000;
				end else begin
					value <= vsum[rvn_pkg::BND_W-1:0];
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire
